// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i with active-low rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/mlsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlsd_pkg
// shared constants, types and helpers of the multi-lane symbol delay block
// ----------------------------------------------------------------------------
package mlsd_pkg;

  localparam int LANES_DEF     = 24;
  localparam int MAX_DELAY_DEF = 128;

  localparam int SYM_W      = 8;
  localparam int LANE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SEL_W      = 5;
  localparam int STORE_W    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_VALUE  = 2'd1;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             padded;
    logic             error;
    logic [SYM_W-1:0] symbol;
  } store_word_t;

  // index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== hdl/mlsd_ifs.sv =====
// ----------------------------------------------------------------------------
// mlsd_ifs
// valid/ready channels for incoming symbols and delayed symbols
// ----------------------------------------------------------------------------
interface mlsd_in_if import mlsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [SYM_W-1:0] symbol;
  logic             symbol_error;
  logic             symbol_padded;

  modport source (output valid, operation, symbol, symbol_error, symbol_padded,
                  input ready);
  modport sink   (input valid, operation, symbol, symbol_error, symbol_padded,
                  output ready);
endinterface

interface mlsd_out_if import mlsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  delayed_symbol;
  logic              delayed_error;
  logic              delayed_padded;
  logic [LANE_W-1:0] lane;
  logic              frame_end;

  modport source (output valid, delayed_symbol, delayed_error, delayed_padded, lane,
                  frame_end, input ready);
  modport sink   (input valid, delayed_symbol, delayed_error, delayed_padded, lane,
                  frame_end, output ready);
endinterface

// ===== hdl/mlsd_store.sv =====
// ----------------------------------------------------------------------------
// mlsd_store
// single-clock symbol memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mlsd_store import mlsd_pkg::*; #(
  parameter int DEPTH = LANES_DEF * MAX_DELAY_DEF,
  parameter int WIDTH = STORE_W,
  localparam int AW   = idx_w(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // read-first: a read of the entry written in the same cycle gets the old word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/mlsd_dtab.sv =====
// ----------------------------------------------------------------------------
// mlsd_dtab
// lane delay table with its config registers and the fill-complete check
// ----------------------------------------------------------------------------
module mlsd_dtab import mlsd_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  localparam int LW       = idx_w(LANES),
  localparam int DW       = $clog2(MAX_DELAY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [LW-1:0]         lane_i,
  input  logic [DW-1:0]         frames_i,
  output logic [DW-1:0]         delay_o,
  output logic                  fill_ok_o
);

  logic [SEL_W-1:0] sel_q;
  logic [DW-1:0]    delay_q [LANES];
  logic [10:0]      dval_ext;
  logic [DW-1:0]    dval_sat;
  logic             sel_ok;
  logic [LANES-1:0] lane_ok;

  always_comb begin
    dval_ext = 11'(cfg_data_i);
    if (dval_ext > 11'(MAX_DELAY)) begin
      dval_ext = 11'(MAX_DELAY);
    end
    dval_sat = DW'(dval_ext);
  end

  assign sel_ok = (32'(sel_q) < LANES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      for (int i = 0; i < LANES; i++) begin
        delay_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DELAY_SELECT) begin
        sel_q <= cfg_data_i[SEL_W-1:0];
      end else if (cfg_idx_i == CFG_DELAY_VALUE) begin
        for (int i = 0; i < LANES; i++) begin
          if (sel_ok && (32'(sel_q) == i)) begin
            delay_q[i] <= dval_sat;
          end
        end
      end
    end
  end

  // output starts once every lane has seen at least its delay in frames
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_ok[i] = (delay_q[i] <= frames_i);
    end
  end

  assign fill_ok_o = &lane_ok;
  assign delay_o   = delay_q[lane_i];

endmodule

// ===== hdl/multi_lane_symbol_delay.sv =====
// ----------------------------------------------------------------------------
// multi_lane_symbol_delay
// per-lane symbol delay lines held in one memory, one region per lane
//
//   channel   dir   handshake        carries
//   in_i      in    valid/ready      operation, symbol, symbol_error, symbol_padded
//   out_o     out   valid/ready      delayed_symbol, delayed_error, delayed_padded,
//                                    lane, frame_end
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// one item per cycle while in_i.ready is high; results leave the output register
// each push does one read and one write of the symbol memory in its accept cycle
// a stage register and an output register let a new item in while a result waits
// in_i.ready drops only when both are full and out_o is stalled
// async active-low reset clears all counters and the delay table; no memory sweep
// ----------------------------------------------------------------------------
module multi_lane_symbol_delay import mlsd_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mlsd_in_if.sink               in_i,
  mlsd_out_if.source            out_o
);

`include "assert_macros.svh"

  localparam int LW    = idx_w(LANES);
  localparam int DW    = $clog2(MAX_DELAY + 1);
  localparam int PW    = idx_w(MAX_DELAY);
  localparam int SW    = PW + 1;
  localparam int DEPTH = LANES * MAX_DELAY;
  localparam int AW    = idx_w(DEPTH);

  logic [LW-1:0] lane_q;
  logic [DW-1:0] frames_q;
  logic [PW-1:0] fptr_q;

  logic          acc, push, flush, out_free, last_lane;
  logic [DW-1:0] lane_delay;
  logic          fill_ok;

  logic [AW-1:0] base, wr_addr, rd_addr;
  logic [SW-1:0] rd_off;
  store_word_t   cur_word, rd_word, res_word;

  logic          s1_valid_q, s1_bypass_q, s1_last_q;
  logic [LW-1:0] s1_lane_q;
  store_word_t   s1_cur_q;

  logic          o_valid_q, o_last_q;
  logic [LW-1:0] o_lane_q;
  store_word_t   o_word_q;

  assign out_free  = !o_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_free;
  assign acc       = in_i.valid && in_i.ready;
  assign push      = acc && (in_i.operation == OP_PUSH);
  assign flush     = acc && (in_i.operation == OP_FLUSH);
  assign last_lane = (lane_q == LW'(LANES - 1));

  mlsd_dtab #(
    .LANES     (LANES),
    .MAX_DELAY (MAX_DELAY)
  ) u_dtab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .lane_i     (lane_q),
    .frames_i   (frames_q),
    .delay_o    (lane_delay),
    .fill_ok_o  (fill_ok)
  );

  // every lane's write position equals the frame position, since lanes go in order
  always_comb begin
    base    = AW'(32'(lane_q) * MAX_DELAY);
    wr_addr = base + AW'(fptr_q);
    rd_off  = SW'(fptr_q) + SW'(MAX_DELAY) - SW'(lane_delay);
    if (rd_off >= SW'(MAX_DELAY)) begin
      rd_off = rd_off - SW'(MAX_DELAY);
    end
    rd_addr = base + AW'(rd_off);
  end

  assign cur_word.padded = in_i.symbol_padded;
  assign cur_word.error  = in_i.symbol_error;
  assign cur_word.symbol = in_i.symbol;

  mlsd_store #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_addr_i (wr_addr),
    .wr_data_i (cur_word),
    .rd_en_i   (push),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  // lane, frame position and fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q   <= '0;
      frames_q <= '0;
      fptr_q   <= '0;
    end else if (flush) begin
      lane_q   <= '0;
      frames_q <= '0;
      fptr_q   <= '0;
    end else if (push) begin
      if (last_lane) begin
        lane_q <= '0;
        if (frames_q != DW'(MAX_DELAY)) begin
          frames_q <= frames_q + DW'(1);
        end
        if (fptr_q == PW'(MAX_DELAY - 1)) begin
          fptr_q <= '0;
        end else begin
          fptr_q <= fptr_q + PW'(1);
        end
      end else begin
        lane_q <= lane_q + LW'(1);
      end
    end
  end

  // valid bits of the read stage and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (out_free) begin
        o_valid_q <= s1_valid_q;
      end
      if (acc) begin
        s1_valid_q <= push && fill_ok;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  assign res_word = s1_bypass_q ? s1_cur_q : rd_word;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_bypass_q <= (lane_delay == '0);
      s1_cur_q    <= cur_word;
      s1_lane_q   <= lane_q;
      s1_last_q   <= last_lane;
    end
    if (out_free && s1_valid_q) begin
      o_word_q <= res_word;
      o_lane_q <= s1_lane_q;
      o_last_q <= s1_last_q;
    end
  end

  assign out_o.valid          = o_valid_q;
  assign out_o.delayed_symbol = o_word_q.symbol;
  assign out_o.delayed_error  = o_word_q.error;
  assign out_o.delayed_padded = o_word_q.padded;
  assign out_o.lane           = LANE_W'(o_lane_q);
  assign out_o.frame_end      = o_last_q;

  `ASSERT_ALWAYS(a_lane_range, 32'(lane_q) < LANES, "lane counter out of range")
  `ASSERT_ALWAYS(a_frames_sat, 32'(frames_q) <= MAX_DELAY, "frame count past saturation")
  `ASSERT_CLK(a_no_early_result, (push && !fill_ok) |=> !s1_valid_q, "result before fill")
  `ASSERT_CLK(a_flush_clears, flush |=> (lane_q == '0) && (frames_q == '0) && !s1_valid_q,
              "flush left state behind")

endmodule

// ===== test/multi_lane_symbol_delay_test.sv =====
// ----------------------------------------------------------------------------
// multi_lane_symbol_delay_test
// self-checking bench for the per-lane symbol delay lines: a driver feeds
// pushes and flushes from a queue, a scoreboard tracks the lane delay lines
// and the frame count, and a monitor compares every delayed symbol in order
// ----------------------------------------------------------------------------
module multi_lane_symbol_delay_test;
  import mlsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES        = LANES_DEF;
  localparam int MAX_DELAY    = MAX_DELAY_DEF;
  localparam int LONG_STALL   = 300;
  localparam int SETTLE       = 6;
  localparam int IDLE_LIMIT   = 2000;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [SYM_W-1:0] symbol;
    logic             symbol_error;
    logic             symbol_padded;
  } sym_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  delayed_symbol;
    logic              delayed_error;
    logic              delayed_padded;
    logic [LANE_W-1:0] lane;
    logic              frame_end;
  } delayed_item_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mlsd_in_if  sym_in ();
  mlsd_out_if sym_out ();

  multi_lane_symbol_delay i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (sym_in),
    .out_o      (sym_out)
  );

  // delay line state as the block should hold it
  store_word_t      line_mem [LANES*MAX_DELAY];
  int               line_ptr [LANES];
  logic [7:0]       lane_delay [LANES];
  logic [SEL_W-1:0] lane_sel;
  int               whole_frames;
  int               next_lane;

  sym_item_t     feed_q [$];
  delayed_item_t due_q [$];
  sym_item_t     on_offer;

  int items_queued;
  int items_taken;
  int results_seen;
  int err_cnt;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_req;
  int stall_seen;
  int stall_left;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                          input logic [CFG_DATA_W-1:0] data);
    logic [7:0] dly;
    case (idx)
      CFG_DELAY_SELECT: lane_sel = data[SEL_W-1:0];
      CFG_DELAY_VALUE: begin
        dly = (data > MAX_DELAY) ? 8'(MAX_DELAY) : data;
        // a select beyond the last lane leaves the table alone
        if (lane_sel < LANES) lane_delay[lane_sel] = dly;
      end
      default: ;
    endcase
  endfunction

  function automatic void shift_lanes(input sym_item_t it);
    int            ln;
    int            ptr;
    int            dly;
    int            top;
    bit            emit;
    store_word_t   cur;
    store_word_t   word;
    delayed_item_t res;
    if (it.operation == OP_FLUSH) begin
      foreach (line_ptr[i]) line_ptr[i] = 0;
      whole_frames = 0;
      next_lane = 0;
      return;
    end
    top = 0;
    foreach (lane_delay[i]) if (lane_delay[i] > top) top = lane_delay[i];
    emit = (whole_frames >= top);
    ln = next_lane;
    dly = lane_delay[ln];
    ptr = line_ptr[ln];
    cur.symbol = it.symbol;
    cur.error  = it.symbol_error;
    cur.padded = it.symbol_padded;
    word = (dly == 0) ? cur : line_mem[ln*MAX_DELAY + (ptr + MAX_DELAY - dly) % MAX_DELAY];
    line_mem[ln*MAX_DELAY + ptr] = cur;
    line_ptr[ln] = (ptr + 1) % MAX_DELAY;
    if (ln == LANES - 1) begin
      next_lane = 0;
      if (whole_frames < MAX_DELAY) whole_frames++;
    end else begin
      next_lane = ln + 1;
    end
    if (emit) begin
      res.delayed_symbol = word.symbol;
      res.delayed_error  = word.error;
      res.delayed_padded = word.padded;
      res.lane           = LANE_W'(ln);
      res.frame_end      = (ln == LANES - 1);
      due_q.push_back(res);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_in.valid         <= 1'b0;
      sym_in.operation     <= OP_PUSH;
      sym_in.symbol        <= '0;
      sym_in.symbol_error  <= 1'b0;
      sym_in.symbol_padded <= 1'b0;
    end else begin
      if (sym_in.valid && sym_in.ready) begin
        shift_lanes(on_offer);
        items_taken++;
      end
      if (!sym_in.valid || sym_in.ready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_offer = feed_q.pop_front();
          sym_in.operation     <= on_offer.operation;
          sym_in.symbol        <= on_offer.symbol;
          sym_in.symbol_error  <= on_offer.symbol_error;
          sym_in.symbol_padded <= on_offer.symbol_padded;
          sym_in.valid         <= 1'b1;
        end else begin
          sym_in.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    delayed_item_t want;
    if (!rst_ni) begin
      sym_out.ready <= 1'b0;
      stall_seen    <= 0;
      stall_left    <= 0;
    end else begin
      if (sym_out.valid && sym_out.ready) begin
        results_seen++;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual symbol %0d lane %0d",
                   $time, sym_out.delayed_symbol, sym_out.lane);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          check_field("delayed_symbol", want.delayed_symbol, sym_out.delayed_symbol);
          check_field("delayed_error", want.delayed_error, sym_out.delayed_error);
          check_field("delayed_padded", want.delayed_padded, sym_out.delayed_padded);
          check_field("lane", want.lane, sym_out.lane);
          check_field("frame_end", want.frame_end, sym_out.frame_end);
        end
      end
      if (stall_req != stall_seen) begin
        stall_seen    <= stall_req;
        stall_left    <= LONG_STALL;
        sym_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        sym_out.ready <= 1'b0;
      end else begin
        sym_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (sym_in.valid && sym_in.ready) ||
        (sym_out.valid && sym_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("multi_lane_symbol_delay test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic op, input logic [SYM_W-1:0] sym,
                            input logic err, input logic pad);
    sym_item_t it;
    it.operation     = op;
    it.symbol        = sym;
    it.symbol_error  = err;
    it.symbol_padded = pad;
    feed_q.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random_push();
    queue_item(OP_PUSH, SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
  endtask

  // whole frames of random symbols, now and then a partial frame cut by a flush
  task automatic queue_frames(input int frames, input int flush_pct);
    int cut;
    repeat (frames) begin
      if ($urandom_range(99) < flush_pct) begin
        cut = $urandom_range(LANES - 1);
        repeat (cut) queue_random_push();
        queue_item(OP_FLUSH, SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      end
      repeat (LANES) queue_random_push();
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || due_q.size() != 0) @(posedge clk_i);
    // flushes and filling pushes give no item back
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    apply_reg_write(idx, data);
  endtask

  task automatic set_lane_delay(input int ln, input int dly);
    reg_write(CFG_DELAY_SELECT, CFG_DATA_W'(ln));
    reg_write(CFG_DELAY_VALUE, CFG_DATA_W'(dly));
  endtask

  task automatic end_reg_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_delays(input int hi);
    for (int l = 0; l < LANES; l++) set_lane_delay(l, $urandom_range(hi));
  endtask

  initial begin : main
    int n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DELAY_SELECT;
    cfg_data_i    = '0;
    sym_in.valid  = 1'b0;
    sym_out.ready = 1'b0;
    lane_sel      = '0;
    whole_frames  = 0;
    next_lane     = 0;
    foreach (line_ptr[i]) line_ptr[i] = 0;
    foreach (lane_delay[i]) lane_delay[i] = '0;
    items_queued  = 0;
    items_taken   = 0;
    results_seen  = 0;
    err_cnt       = 0;
    stall_req     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 32;
    recv_idle_pct = 48;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all delays zero: every push comes straight back, extremes first
    queue_item(OP_PUSH, 8'h00, 1'b0, 1'b0);
    queue_item(OP_PUSH, 8'hFF, 1'b1, 1'b1);
    queue_item(OP_PUSH, 8'h80, 1'b1, 1'b0);
    queue_item(OP_PUSH, 8'h7F, 1'b0, 1'b1);
    repeat (LANES - 4) queue_random_push();
    repeat (3) queue_random_push();
    queue_item(OP_FLUSH, 8'hFF, 1'b1, 1'b1);
    queue_frames(6, 25);

    // hold the output long enough for the block to back up
    n = results_seen;
    while (results_seen < n + 10) @(posedge clk_i);
    stall_req = stall_req + 1;
    wait_drained();

    // short delays, plus writes the block must ignore
    program_delays(4);
    reg_write(CFG_DELAY_SELECT, 8'hFF);
    reg_write(CFG_DELAY_VALUE, 8'd9);
    set_lane_delay(LANES, 3);
    reg_write(CFG_SPARE_2, 8'hA5);
    reg_write(CFG_SPARE_3, 8'h5A);
    end_reg_writes();
    queue_frames(8, 8);
    wait_drained();

    // delays raised mid-stream, idling swapped
    send_idle_pct = 48;
    recv_idle_pct = 32;
    program_delays(6);
    set_lane_delay(LANES - 1, 0);
    end_reg_writes();
    queue_frames(8, 8);
    wait_drained();

    // saturating writes and the full line length hold every result back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_lane_delay(3, 255);
    set_lane_delay(10, MAX_DELAY);
    set_lane_delay(LANES - 1, 129);
    end_reg_writes();
    queue_item(OP_FLUSH, 8'h00, 1'b0, 1'b0);
    queue_frames(2, 0);
    wait_drained();

    // deeper delays without a flush; the line has to fill first
    program_delays(10);
    set_lane_delay(0, 0);
    set_lane_delay(10, 10);
    end_reg_writes();
    queue_frames(14, 0);
    wait_drained();

    // delays lowered without a flush
    program_delays(3);
    end_reg_writes();
    queue_frames(4, 20);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("multi_lane_symbol_delay test passed");
    end else begin
      $display("multi_lane_symbol_delay test failed");
    end
    $finish;
  end

endmodule
